FILE: hdl/dqpb_pkg.sv
// ----------------------------------------------------------------------------
// dqpb_pkg
// Shared types and constants of the DNS query packet builder: payload
// structs, register map, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package dqpb_pkg;

  // Fixed packet layout
  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned TAIL_BYTES = 5;
  localparam logic [7:0]  DOT_CHAR   = 8'h2E;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [15:0] QUERY_ID_RST       = 16'h1234;
  localparam logic [15:0] HEADER_FLAGS_RST   = 16'h0100;
  localparam logic [15:0] QUESTION_TYPE_RST  = 16'h0001;
  localparam logic [15:0] QUESTION_CLASS_RST = 16'h0001;

  typedef enum logic [1:0] {
    REG_QUERY_ID       = 2'd0,
    REG_HEADER_FLAGS   = 2'd1,
    REG_QUESTION_TYPE  = 2'd2,
    REG_QUESTION_CLASS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] query_id;
    logic [15:0] header_flags;
    logic [15:0] question_type;
    logic [15:0] question_class;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       name_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       run_last;
    logic       packet_end;
    logic       label_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_LEN,
    ST_DATA,
    ST_TAIL
  } state_t;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_LEN,
    SEL_DATA,
    SEL_TAIL
  } sel_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // input beat accepted this cycle
    logic emit;        // load the output register this cycle
    sel_t sel;         // source of the emitted byte
    logic seq_clr;     // restart the byte counter after this byte
    logic flush_clr;   // label fully emitted: clear count and overflow
    logic run_last;
    logic packet_end;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a byte
    logic in_dot;      // incoming character is a label separator
    logic hdr_end;     // byte counter on the last header byte
    logic tail_end;    // byte counter on the last trailer byte
    logic cnt_zero;    // current label is empty
    logic data_end;    // byte counter on the last label byte
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/dqpb_ram.sv
// ----------------------------------------------------------------------------
// dqpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/dqpb_ctl.sv
// ----------------------------------------------------------------------------
// dqpb_ctl
// Controller: sequences header, label flushes and trailer one byte per
// cycle while the output is free, and tracks whether a query is open.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpb_ctl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  output logic                  in_stall,
  input  wire dqpb_pkg::dp_sts_t sts,
  output dqpb_pkg::dp_cmd_t     cmd
);

  import dqpb_pkg::*;

  state_t     state_r, state_nxt;
  logic       in_query_r;
  logic       last_r;
  logic [1:0] flush_left_r;   // label flushes still owed by this item
  state_t     after_flush;
  logic       flush_run_last;

  // Where to go once the current label is out
  always_comb begin
    if (flush_left_r == 2'd2) begin
      after_flush = ST_LEN;
    end else if (last_r) begin
      after_flush = ST_TAIL;
    end else begin
      after_flush = ST_IDLE;
    end
    flush_run_last = (flush_left_r == 2'd1) && !last_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_query_r) begin
            state_nxt = ST_HDR;
          end else if (sts.in_dot || in_last) begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_HDR: begin
        if (sts.out_free && sts.hdr_end) begin
          state_nxt = (flush_left_r != 2'd0) ? ST_LEN : ST_IDLE;
        end
      end
      ST_LEN: begin
        if (sts.out_free) begin
          state_nxt = sts.cnt_zero ? after_flush : ST_DATA;
        end
      end
      ST_DATA: begin
        if (sts.out_free && sts.data_end) begin
          state_nxt = after_flush;
        end
      end
      ST_TAIL: begin
        if (sts.out_free && sts.tail_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.sel        = SEL_HDR;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_HDR: begin
        cmd.sel      = SEL_HDR;
        cmd.emit     = sts.out_free;
        cmd.seq_clr  = sts.hdr_end;
        cmd.run_last = sts.hdr_end && (flush_left_r == 2'd0);
      end
      ST_LEN: begin
        cmd.sel       = SEL_LEN;
        cmd.emit      = sts.out_free;
        cmd.seq_clr   = 1'b1;
        cmd.flush_clr = sts.cnt_zero;
        cmd.run_last  = sts.cnt_zero && flush_run_last;
      end
      ST_DATA: begin
        cmd.sel       = SEL_DATA;
        cmd.emit      = sts.out_free;
        cmd.seq_clr   = sts.data_end;
        cmd.flush_clr = sts.data_end;
        cmd.run_last  = sts.data_end && flush_run_last;
      end
      ST_TAIL: begin
        cmd.sel        = SEL_TAIL;
        cmd.emit       = sts.out_free;
        cmd.seq_clr    = sts.tail_end;
        cmd.run_last   = sts.tail_end;
        cmd.packet_end = sts.tail_end;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State and item bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_query_r   <= 1'b0;
      last_r       <= 1'b0;
      flush_left_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        last_r       <= in_last;
        flush_left_r <= {1'b0, sts.in_dot} + {1'b0, in_last};
        in_query_r   <= 1'b1;
      end
      if (cmd.emit && cmd.flush_clr) begin
        flush_left_r <= flush_left_r - 2'd1;
      end
      if (cmd.emit && cmd.packet_end) begin
        in_query_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dqpb_dp.sv
// ----------------------------------------------------------------------------
// dqpb_dp
// Datapath: label buffer, label count and overflow flag, byte counter,
// packet byte selection and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpb_dp #(
  parameter int unsigned LABEL_MAX = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dqpb_pkg::in_item_t   in_data,
  input  wire dqpb_pkg::cfg_regs_t  cfg,
  input  wire dqpb_pkg::dp_cmd_t    cmd,
  output dqpb_pkg::dp_sts_t         sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dqpb_pkg::out_item_t       out_data
);

  import dqpb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(LABEL_MAX + 1);
  localparam int unsigned ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int unsigned SEQ_W  = (CNT_W > 4) ? CNT_W : 4;

  logic [CNT_W-1:0]  count_r;
  logic              ovf_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [SEQ_W-1:0]  seq_inc;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_dot;
  logic              has_room;
  logic              buf_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        hdr_byte;
  logic [7:0]        tail_byte;
  out_item_t         byte_sel;

  assign in_dot   = (in_data.name_char == DOT_CHAR);
  assign has_room = (count_r < CNT_W'(LABEL_MAX));
  assign buf_we   = cmd.load && !in_dot && has_room;
  assign seq_inc  = seq_r + SEQ_W'(1);

  // Status to the controller
  always_comb begin
    sts.out_free = !out_valid_r || !out_stall;
    sts.in_dot   = in_dot;
    sts.hdr_end  = (seq_r == SEQ_W'(HDR_BYTES - 1));
    sts.tail_end = (seq_r == SEQ_W'(TAIL_BYTES - 1));
    sts.cnt_zero = (count_r == '0);
    sts.data_end = (seq_inc == SEQ_W'(count_r));
  end

  // Read ahead: next entry once this one goes out, else hold the current one
  always_comb begin
    if (cmd.sel == SEL_DATA) begin
      if (cmd.emit && !sts.data_end) begin
        rd_addr = seq_inc[ADDR_W-1:0];
      end else begin
        rd_addr = seq_r[ADDR_W-1:0];
      end
    end else begin
      rd_addr = '0;
    end
  end

  dqpb_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_MAX),
    .ADDR_W(ADDR_W)
  ) u_label_ram (
    .clk  (clk),
    .we   (buf_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(in_data.name_char),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Header bytes: id, flags, one question, three zero counts
  always_comb begin
    case (seq_r[3:0])
      4'd0:    hdr_byte = cfg.query_id[15:8];
      4'd1:    hdr_byte = cfg.query_id[7:0];
      4'd2:    hdr_byte = cfg.header_flags[15:8];
      4'd3:    hdr_byte = cfg.header_flags[7:0];
      4'd5:    hdr_byte = 8'd1;
      default: hdr_byte = 8'd0;
    endcase
  end

  // Trailer bytes: terminator, qtype, qclass
  always_comb begin
    case (seq_r[2:0])
      3'd1:    tail_byte = cfg.question_type[15:8];
      3'd2:    tail_byte = cfg.question_type[7:0];
      3'd3:    tail_byte = cfg.question_class[15:8];
      3'd4:    tail_byte = cfg.question_class[7:0];
      default: tail_byte = 8'd0;
    endcase
  end

  // Pick the byte to emit
  always_comb begin
    byte_sel            = '0;
    byte_sel.run_last   = cmd.run_last;
    byte_sel.packet_end = cmd.packet_end;
    case (cmd.sel)
      SEL_HDR:  byte_sel.packet_byte = hdr_byte;
      SEL_LEN: begin
        byte_sel.packet_byte    = 8'(count_r);
        byte_sel.label_overflow = ovf_r;
      end
      SEL_DATA: begin
        byte_sel.packet_byte    = rd_data;
        byte_sel.label_overflow = ovf_r;
      end
      SEL_TAIL: byte_sel.packet_byte = tail_byte;
      default:  byte_sel.packet_byte = 8'd0;
    endcase
  end

  // Label count, overflow flag and byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      seq_r   <= '0;
    end else begin
      if (cmd.load && !in_dot) begin
        if (has_room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        seq_r <= cmd.seq_clr ? '0 : seq_inc;
        if (cmd.flush_clr) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
    end
  end

  // Output register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= byte_sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/dns_query_packet_builder.sv
// ----------------------------------------------------------------------------
// dns_query_packet_builder
// Streams a dotted hostname in, one character per beat, and streams the
// bytes of a DNS query out, one byte per beat.
// ----------------------------------------------------------------------------
// The first character of a query produces the 12-byte header; each dot
// produces a length byte plus the buffered label; the character marked
// name_last closes the open label and appends the zero terminator, qtype
// and qclass. An input beat that only buffers a character does not stall
// the input. Otherwise the item stalls the input until all bytes it
// produces are out, one byte per cycle through the single output register
// while the output is not stalled. Label characters live in a LABEL_MAX-entry
// RAM with registered read, read one entry ahead so the data bytes go out
// back to back. The user must write the configuration registers through
// the APB port only while no query is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_packet_builder #(
  parameter int unsigned LABEL_MAX = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Hostname characters
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire dqpb_pkg::in_item_t                  in_data,
  // Packet bytes
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output dqpb_pkg::out_item_t                      out_data,
  // Configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [dqpb_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [dqpb_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [dqpb_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);

  import dqpb_pkg::*;

  cfg_regs_t cfg_r;
  reg_idx_t  reg_idx;
  logic      cfg_wr;
  logic [15:0] rd_word;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_id       <= QUERY_ID_RST;
      cfg_r.header_flags   <= HEADER_FLAGS_RST;
      cfg_r.question_type  <= QUESTION_TYPE_RST;
      cfg_r.question_class <= QUESTION_CLASS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QUERY_ID:       cfg_r.query_id       <= cfg_pwdata[15:0];
        REG_HEADER_FLAGS:   cfg_r.header_flags   <= cfg_pwdata[15:0];
        REG_QUESTION_TYPE:  cfg_r.question_type  <= cfg_pwdata[15:0];
        REG_QUESTION_CLASS: cfg_r.question_class <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_QUERY_ID:       rd_word = cfg_r.query_id;
      REG_HEADER_FLAGS:   rd_word = cfg_r.header_flags;
      REG_QUESTION_TYPE:  rd_word = cfg_r.question_type;
      REG_QUESTION_CLASS: rd_word = cfg_r.question_class;
      default:            rd_word = '0;
    endcase
  end

  assign cfg_prdata = CFG_DATA_W'(rd_word);

  dqpb_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_last (in_data.name_last),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  dqpb_dp #(
    .LABEL_MAX(LABEL_MAX)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/dqpb_checker.sv
// ----------------------------------------------------------------------------
// dqpb_checker
// Port-level checks of the DNS query packet builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpb_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire dqpb_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire dqpb_pkg::out_item_t out_data
);

  import dqpb_pkg::*;

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat present after reset");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // The packet's final byte closes the run and is never part of a label
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_end |-> out_data.run_last && !out_data.label_overflow)
    else $error("packet end without run end or with overflow flag");

  // A final character always produces bytes, so input must stall next
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.name_last |=> in_stall)
    else $error("final character accepted without closing the packet");

endmodule

bind dns_query_packet_builder dqpb_checker u_dqpb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

FILE: test/tb_dns_query_packet_builder.sv
// ----------------------------------------------------------------------------
// tb_dns_query_packet_builder
// Self-checking bench for the DNS query packet builder. It feeds hostname
// characters through the input channel and runs a cycle-free predictor of
// the packet bytes beside the block. Every byte beat that leaves the block
// is compared field by field with the oldest predicted byte. The run starts
// with a short table of hand-picked characters, then sends random
// hostnames under several register settings. Both sides idle at random,
// and the receiver also holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dns_query_packet_builder;
  import dqpb_pkg::*;

  localparam int unsigned LABEL_MAX    = 32;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned SETTLE_LIMIT = 100000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASE_CHARS  = 68;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  // Hand-written expectation for the last byte beat caused by one character
  typedef struct packed {
    logic       typed;
    logic [7:0] last_byte;
    logic       last_end;
    logic       last_ovf;
  } tail_note_t;

  typedef struct packed {
    in_item_t   item;
    tail_note_t note;
  } probe_row_t;

  // Directed characters, right after reset with the default registers
  localparam probe_row_t PROBE_ROWS [16] = '{
    '{'{8'h00, 1'b0}, '{1'b1, 8'h00, 1'b0, 1'b0}},  // header only, low char
    '{'{8'hFF, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},  // buffered, high char
    '{'{8'h2E, 1'b0}, '{1'b1, 8'hFF, 1'b0, 1'b0}},  // flush two-byte label
    '{'{8'h2E, 1'b0}, '{1'b1, 8'h00, 1'b0, 1'b0}},  // two dots in a row
    '{'{8'h61, 1'b1}, '{1'b1, 8'h01, 1'b1, 1'b0}},  // close query
    '{'{8'h2E, 1'b1}, '{1'b1, 8'h01, 1'b1, 1'b0}},  // lone final dot
    '{'{8'h7F, 1'b1}, '{1'b1, 8'h01, 1'b1, 1'b0}},  // one-char hostname
    '{'{8'h80, 1'b0}, '{1'b1, 8'h00, 1'b0, 1'b0}},
    '{'{8'h55, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{8'hAA, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{8'h2E, 1'b1}, '{1'b0, 8'h00, 1'b0, 1'b0}},  // final dot after label
    '{'{8'h41, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{8'h2E, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{8'h2E, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{8'h42, 1'b0}, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{8'h43, 1'b1}, '{1'b0, 8'h00, 1'b0, 1'b0}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tail_note_t item_note;

  // Predictor copy of the registers and the label state
  logic [15:0] qid_reg    = QUERY_ID_RST;
  logic [15:0] flags_reg  = HEADER_FLAGS_RST;
  logic [15:0] qtype_reg  = QUESTION_TYPE_RST;
  logic [15:0] qclass_reg = QUESTION_CLASS_RST;
  logic        mid_query  = 1'b0;
  logic [7:0]  lbl_buf [LABEL_MAX];
  int unsigned lbl_len    = 0;
  logic        lbl_trunc  = 1'b0;

  out_item_t step_bytes[$];
  out_item_t expected_bytes[$];
  in_item_t  host_chars[$];
  int unsigned n_mismatch = 0;
  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  dns_query_packet_builder #(
    .LABEL_MAX (LABEL_MAX)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bail out if the run hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Packet byte predictor
  // --------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b, logic trunc);
    out_item_t r;
    r = '0;
    r.packet_byte    = b;
    r.label_overflow = trunc;
    step_bytes = {step_bytes, r};
  endfunction

  function automatic void put_word(logic [15:0] w);
    put_byte(w[15:8], 1'b0);
    put_byte(w[7:0], 1'b0);
  endfunction

  // Emit the open label as length byte plus kept characters, then clear it
  function automatic void close_label();
    int unsigned i;
    put_byte(lbl_len[7:0], lbl_trunc);
    for (i = 0; i < lbl_len; i++) put_byte(lbl_buf[i], lbl_trunc);
    lbl_len   = 0;
    lbl_trunc = 1'b0;
  endfunction

  function automatic void predict_packet_bytes(in_item_t it);
    step_bytes.delete();
    // open a query with the 12-byte header
    if (!mid_query) begin
      put_word(qid_reg);
      put_word(flags_reg);
      put_word(16'd1);
      put_word(16'd0);
      put_word(16'd0);
      put_word(16'd0);
      mid_query = 1'b1;
      lbl_len   = 0;
      lbl_trunc = 1'b0;
    end
    // buffer, flush on dot, or drop past the label limit
    if (it.name_char == DOT_CHAR) begin
      close_label();
    end else if (lbl_len < LABEL_MAX) begin
      lbl_buf[lbl_len] = it.name_char;
      lbl_len++;
    end else begin
      lbl_trunc = 1'b1;
    end
    // close the name and append terminator, qtype and qclass
    if (it.name_last) begin
      close_label();
      put_byte(8'h00, 1'b0);
      put_word(qtype_reg);
      put_word(qclass_reg);
      step_bytes[step_bytes.size() - 1].packet_end = 1'b1;
      mid_query = 1'b0;
    end
    if (step_bytes.size() > 0) begin
      step_bytes[step_bytes.size() - 1].run_last = 1'b1;
    end
  endfunction

  function automatic void flag_mismatch(string what, out_item_t want, out_item_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%t mismatch (%s): exp byte=%02h rl=%0b end=%0b ovf=%0b",
               $realtime, what, want.packet_byte, want.run_last, want.packet_end,
               want.label_overflow);
    if (n_mismatch <= 10)
      $display("%t          got byte=%02h rl=%0b end=%0b ovf=%0b", $realtime,
               got.packet_byte, got.run_last, got.packet_end, got.label_overflow);
  endfunction

  // --------------------------------------------------------------------------
  // Predict on every accepted character beat, check every accepted byte beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      predict_packet_bytes(in_data);
      // take the hand-written value for the last byte where the row has one
      if (item_note.typed && step_bytes.size() > 0) begin
        want = step_bytes.pop_back();
        want.packet_byte    = item_note.last_byte;
        want.packet_end     = item_note.last_end;
        want.label_overflow = item_note.last_ovf;
        step_bytes = {step_bytes, want};
      end
      foreach (step_bytes[k]) expected_bytes = {expected_bytes, step_bytes[k]};
    end
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        flag_mismatch("byte with none expected", '0, out_data);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.packet_byte !== want.packet_byte ||
            out_data.run_last !== want.run_last ||
            out_data.packet_end !== want.packet_end ||
            out_data.label_overflow !== want.label_overflow)
          flag_mismatch("field", want, out_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side helpers
  // --------------------------------------------------------------------------
  // Offer one character beat, hold it until taken, then maybe go quiet
  task automatic offer_char(input in_item_t it, input tail_note_t note);
    in_valid  <= 1'b1;
    in_data   <= it;
    item_note <= note;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted byte has come out
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_bytes.size() != 0 && waited < SETTLE_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, then back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= {16'h0000, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_QUERY_ID:       qid_reg    = val;
      REG_HEADER_FLAGS:   flags_reg  = val;
      REG_QUESTION_TYPE:  qtype_reg  = val;
      REG_QUESTION_CLASS: qclass_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == DOT_CHAR) c = ~DOT_CHAR;
    return c;
  endfunction

  // Build one hostname: mostly dotted labels, some long ones, some noise
  task automatic make_hostname();
    in_item_t c;
    int unsigned n_lbl, len, k, j;
    host_chars.delete();
    c = '0;
    if ($urandom_range(0, 7) == 0) begin
      // noise: dots anywhere, stray end marks
      len = $urandom_range(1, 24);
      for (k = 0; k < len; k++) begin
        c.name_char = ($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255));
        c.name_last = ($urandom_range(0, 9) == 0);
        host_chars = {host_chars, c};
      end
    end else begin
      n_lbl = $urandom_range(1, 4);
      for (k = 0; k < n_lbl; k++) begin
        if (k > 0) begin
          c.name_char = DOT_CHAR;
          host_chars = {host_chars, c};
        end
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(LABEL_MAX - 2, LABEL_MAX + 6)
                                          : $urandom_range(0, 8);
        for (j = 0; j < len; j++) begin
          c.name_char = label_char();
          host_chars = {host_chars, c};
        end
      end
      // trailing dot now and then
      if ($urandom_range(0, 5) == 0) begin
        c.name_char = DOT_CHAR;
        host_chars = {host_chars, c};
      end
    end
    if (host_chars.size() == 0) begin
      c.name_char = label_char();
      host_chars = {host_chars, c};
    end
    // mark the end of the hostname
    host_chars[host_chars.size() - 1].name_last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph, sent, r;
    logic [15:0] v [4];
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    item_note   <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (r = 0; r < $size(PROBE_ROWS); r++)
      offer_char(PROBE_ROWS[r].item, PROBE_ROWS[r].note);
    settle();

    // random hostnames under all-ones, all-zeros and random registers
    for (ph = 0; ph < 4; ph++) begin
      for (r = 0; r < 4; r++) begin
        case (ph)
          0:       v[r] = 16'hFFFF;
          1:       v[r] = 16'h0000;
          default: v[r] = 16'($urandom_range(0, 65535));
        endcase
      end
      write_reg(REG_QUERY_ID, v[0]);
      write_reg(REG_HEADER_FLAGS, v[1]);
      write_reg(REG_QUESTION_TYPE, v[2]);
      write_reg(REG_QUESTION_CLASS, v[3]);
      // back up the block once; run the last phase without any idling
      if (ph == 1) hold_req = 1'b1;
      if (ph == 3) calm = 1'b1;
      sent = 0;
      while (sent < PHASE_CHARS) begin
        make_hostname();
        foreach (host_chars[k]) offer_char(host_chars[k], '0);
        sent += host_chars.size();
      end
      settle();
    end

    if (expected_bytes.size() != 0) begin
      $display("%0d predicted bytes never came out", expected_bytes.size());
      n_mismatch += expected_bytes.size();
    end
    if (n_mismatch == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
